### src/rcbs_pkg.sv
// Shared widths, codes and types of the rainbow clique branch selector.
package rcbs_pkg;

    localparam int OP_W      = 2;
    localparam int PT_W      = 16;
    localparam int COLOR_W   = 4;
    localparam int DEPTH_W   = 4;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 3;

    // configuration widths
    localparam int NCOL_W    = 5;
    localparam int NPTS_W    = 17;
    localparam int NC_W      = 7;   // active color count, covers MAX_COLORS up to 127
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam int DEPTH_SLOTS = 16;
    localparam int QUEUE_DEPTH = 2;

    // register select (paddr bit 2)
    localparam logic REG_NUM_COLORS = 1'b0;
    localparam logic REG_NUM_POINTS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SELECT = 2'd1,
        OP_ADD    = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_POINT_RANGE = 3'd1,
        ST_COLOR_RANGE = 3'd2,
        ST_SAT_LISTED  = 3'd3,
        ST_ALREADY_SAT = 3'd4,
        ST_WRONG_COLOR = 3'd5,
        ST_NOT_SAT     = 3'd6,
        ST_LIST_FULL   = 3'd7
    } t_status;

    typedef struct packed {
        t_op                 op;
        logic [PT_W-1:0]     point;
        logic [COLOR_W-1:0]  color;
        logic [DEPTH_W-1:0]  depth;
        t_status             status;   // range checks done at the front
    } t_cmd;

    typedef struct packed {
        logic [PT_W-1:0]     candidate;
        logic [COLOR_W-1:0]  chosen_color;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_res;

endpackage

### src/rcbs_ifs.sv
// Valid/ready stream interfaces for the input and result channels.
interface rcbs_in_if;
    import rcbs_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [PT_W-1:0]    point;
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] depth;

    modport source (output valid, operation, point, color, depth, input ready);
    modport sink   (input valid, operation, point, color, depth, output ready);
endinterface

interface rcbs_out_if;
    import rcbs_pkg::*;

    logic                valid;
    logic                ready;
    logic [PT_W-1:0]     candidate;
    logic [COLOR_W-1:0]  chosen_color;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, candidate, chosen_color, count, status, last,
                    input ready);
    modport sink   (input valid, candidate, chosen_color, count, status, last,
                    output ready);
endinterface

### src/rainbow_clique_branch_selector_core.sv
// Top level: configuration registers and the front, queue and back end.
//
// Input channel i_in carries one command per transfer: load a point, select
// candidates, add or delete a satisfied color. Result channel o_out gives one
// transfer per load/add/delete and one or more per select (last marks the
// final one). Both use valid/ready; a transfer happens when both are high.
// The APB port holds num_colors (address 0) and num_points (address 4); write
// it only while the block is idle.
// Load, add and delete stream through the back end at one per cycle when the
// output is taken. A select leaves the queue, then scans the colors in turn,
// then reads each list entry (S_RD, then S_CHK) up to the last match of the
// chosen color: the walk is paced by the list memory's registered read.
// A load, add or delete result passes the queue, then the output register.
// A two-entry queue lets the front keep accepting while the back is busy; a
// stalled receiver holds the output register and backs up the queue.
// Reset empties the list, zeroes the tallies and flags and sets the registers
// to 16 colors and 65536 points; no clearing pass is needed.
module rainbow_clique_branch_selector_core #(
    parameter int LIST_DEPTH = 64,
    parameter int MAX_COLORS = 16,
    parameter int POINT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rcbs_in_if.sink                       i_in,
    rcbs_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcbs_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcbs_pkg::DATA_W-1:0]   pwdata,
    output logic [rcbs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import rcbs_pkg::*;

    logic [NCOL_W-1:0] r_num_colors;
    logic [NPTS_W-1:0] r_num_points;
    logic [NC_W-1:0]   nc;
    logic              wr_en;
    logic              q_push, q_full, q_valid, q_pop;
    t_cmd              push_cmd, q_cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors <= NCOL_W'(16);
            r_num_points <= NPTS_W'(65536);
        end else if (wr_en) begin
            case (paddr[2])
                REG_NUM_COLORS: r_num_colors <= pwdata[NCOL_W-1:0];
                REG_NUM_POINTS: r_num_points <= pwdata[NPTS_W-1:0];
                default: begin
                    r_num_colors <= r_num_colors;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NUM_COLORS: prdata = DATA_W'(r_num_colors);
            REG_NUM_POINTS: prdata = DATA_W'(r_num_points);
            default:        prdata = '0;
        endcase
    end

    // colors above MAX_COLORS act as MAX_COLORS
    assign nc = (NC_W'(r_num_colors) > NC_W'(MAX_COLORS)) ? NC_W'(MAX_COLORS)
                                                          : NC_W'(r_num_colors);

    rcbs_front u_front (
        .i_in         (i_in),
        .i_nc         (nc),
        .i_num_points (r_num_points),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    rcbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    rcbs_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .MAX_COLORS (MAX_COLORS),
        .POINT_BITS (POINT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_nc      (nc),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

### src/rcbs_front.sv
// Front end: accepts input transfers, decodes them and runs the range checks.
module rcbs_front (
    rcbs_in_if.sink                   i_in,
    input  logic [rcbs_pkg::NC_W-1:0] i_nc,
    input  logic [rcbs_pkg::NPTS_W-1:0] i_num_points,
    input  logic                      i_full,
    output logic                      o_push,
    output rcbs_pkg::t_cmd            o_cmd
);
    import rcbs_pkg::*;

    logic pt_bad;
    logic col_bad;
    t_op  op;

    assign op      = t_op'(i_in.operation);
    assign pt_bad  = NPTS_W'(i_in.point) >= i_num_points;
    assign col_bad = NC_W'(i_in.color) >= i_nc;

    always_comb begin
        o_cmd.op    = op;
        o_cmd.point = i_in.point;
        o_cmd.color = i_in.color;
        o_cmd.depth = i_in.depth;
        case (op)
            OP_LOAD: begin
                if (pt_bad) begin
                    o_cmd.status = ST_POINT_RANGE;
                end else if (col_bad) begin
                    o_cmd.status = ST_COLOR_RANGE;
                end else begin
                    o_cmd.status = ST_OK;
                end
            end
            OP_SELECT: begin
                o_cmd.status = ST_OK;
            end
            default: begin
                o_cmd.status = col_bad ? ST_COLOR_RANGE : ST_OK;
            end
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

endmodule

### src/rcbs_queue.sv
// Short command queue between the front end and the execution back end.
module rcbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcbs_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output rcbs_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import rcbs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

    property p_count_step;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1));
    endproperty
    a_count_step: assert property (p_count_step) else $error("queue count slip");

endmodule

### src/rcbs_back.sv
// Back end: list, tallies and flags; runs loads, adds, deletes and the select walk.
module rcbs_back #(
    parameter int LIST_DEPTH = 64,
    parameter int MAX_COLORS = 16,
    parameter int POINT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rcbs_pkg::NC_W-1:0] i_nc,
    input  logic                      i_q_valid,
    input  rcbs_pkg::t_cmd            i_q_cmd,
    output logic                      o_q_pop,
    rcbs_out_if.source                o_out
);
    import rcbs_pkg::*;

    localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W   = $clog2(LIST_DEPTH + 1);
    localparam int CIDX_W  = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_CHK
    } t_state;

    t_state             r_state, n_state;
    logic [NC_W-1:0]    r_c, n_c;
    logic [CIDX_W-1:0]  r_best, n_best;
    logic [LEN_W-1:0]   r_best_n, n_best_n;
    logic               r_found, n_found;
    logic [DEPTH_W-1:0] r_dep, n_dep;
    logic [LEN_W-1:0]   r_i, n_i;
    logic [LEN_W-1:0]   r_k, n_k;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_ov, n_ov;
    t_res               r_out, n_out;

    // storage
    logic [POINT_BITS-1:0] r_list_pt  [LIST_DEPTH];
    logic [COLOR_W-1:0]    r_list_col [LIST_DEPTH];
    logic [POINT_BITS-1:0] r_rd_pt;
    logic [COLOR_W-1:0]    r_rd_col;
    logic [LEN_W-1:0]      r_tally [MAX_COLORS];
    logic [MAX_COLORS-1:0] r_sat;
    logic [COLOR_W-1:0]    r_cad [DEPTH_SLOTS];

    logic              out_free;
    logic              do_load, do_clear, do_rec, do_set, do_unset;
    logic [NC_W-1:0]   q_col_x;
    logic [CIDX_W-1:0] q_cidx;
    logic [CIDX_W-1:0] scan_cidx;

    assign out_free  = !r_ov || o_out.ready;
    assign q_col_x   = NC_W'(i_q_cmd.color);
    assign q_cidx    = q_col_x[CIDX_W-1:0];
    assign scan_cidx = r_c[CIDX_W-1:0];

    always_comb begin
        t_status          v_st;
        logic [LEN_W-1:0] v_t;
        logic             v_s;
        logic             v_last;

        n_state  = r_state;
        n_c      = r_c;
        n_best   = r_best;
        n_best_n = r_best_n;
        n_found  = r_found;
        n_dep    = r_dep;
        n_i      = r_i;
        n_k      = r_k;
        n_len    = r_len;
        n_ov     = r_ov && !o_out.ready;
        n_out    = r_out;
        o_q_pop  = 1'b0;
        do_load  = 1'b0;
        do_clear = 1'b0;
        do_rec   = 1'b0;
        do_set   = 1'b0;
        do_unset = 1'b0;
        v_st     = i_q_cmd.status;
        v_t      = r_tally[scan_cidx];
        v_s      = r_sat[scan_cidx];
        v_last   = (r_k + LEN_W'(1)) == r_best_n;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_cmd.op == OP_SELECT) begin
                    o_q_pop = 1'b1;
                    n_state = S_SCAN;
                    n_c     = '0;
                    n_found = 1'b0;
                    n_dep   = i_q_cmd.depth;
                end else if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.status == ST_OK) begin
                        case (i_q_cmd.op)
                            OP_LOAD: begin
                                if (r_len >= LEN_W'(LIST_DEPTH)) begin
                                    v_st = ST_LIST_FULL;
                                end else begin
                                    do_load = 1'b1;
                                    n_len   = r_len + LEN_W'(1);
                                end
                            end
                            OP_ADD: begin
                                if (r_sat[q_cidx]) begin
                                    v_st = ST_ALREADY_SAT;
                                end else if (i_q_cmd.color != r_cad[i_q_cmd.depth]) begin
                                    v_st = ST_WRONG_COLOR;
                                end else begin
                                    do_set = 1'b1;
                                end
                            end
                            OP_DELETE: begin
                                if (!r_sat[q_cidx]) begin
                                    v_st = ST_NOT_SAT;
                                end else begin
                                    do_unset = 1'b1;
                                end
                            end
                            default: begin
                                v_st = i_q_cmd.status;
                            end
                        endcase
                    end
                    n_ov  = 1'b1;
                    n_out = '{candidate: '0, chosen_color: '0, count: '0,
                              status: v_st, last: 1'b1};
                end
            end
            S_SCAN: begin
                if (r_c >= i_nc) begin
                    if (r_found) begin
                        do_rec  = 1'b1;
                        n_i     = '0;
                        n_k     = '0;
                        n_state = S_RD;
                    end else if (out_free) begin
                        // no unsatisfied color at all: dead branch
                        do_clear = 1'b1;
                        n_len    = '0;
                        n_ov     = 1'b1;
                        n_out    = '{candidate: '0, chosen_color: '0, count: '0,
                                     status: ST_OK, last: 1'b1};
                        n_state  = S_IDLE;
                    end
                end else if (v_s && v_t != '0) begin
                    if (out_free) begin
                        do_clear = 1'b1;
                        n_len    = '0;
                        n_ov     = 1'b1;
                        n_out    = '{candidate: '0, chosen_color: COLOR_W'(r_c),
                                     count: '0, status: ST_SAT_LISTED, last: 1'b1};
                        n_state  = S_IDLE;
                    end
                end else if (!v_s && v_t == '0) begin
                    if (out_free) begin
                        do_clear = 1'b1;
                        n_len    = '0;
                        n_ov     = 1'b1;
                        n_out    = '{candidate: '0, chosen_color: '0, count: '0,
                                     status: ST_OK, last: 1'b1};
                        n_state  = S_IDLE;
                    end
                end else begin
                    if (!v_s && (!r_found || v_t < r_best_n)) begin
                        n_found  = 1'b1;
                        n_best   = scan_cidx;
                        n_best_n = v_t;
                    end
                    n_c = r_c + NC_W'(1);
                end
            end
            S_RD: begin
                // list read of entry r_i lands next cycle
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_i >= r_len) begin
                    do_clear = 1'b1;
                    n_len    = '0;
                    n_state  = S_IDLE;
                end else if (NC_W'(r_rd_col) == NC_W'(r_best)) begin
                    if (out_free) begin
                        n_ov  = 1'b1;
                        n_out = '{candidate: PT_W'(r_rd_pt),
                                  chosen_color: COLOR_W'(r_best),
                                  count: COUNT_W'(r_best_n),
                                  status: ST_OK, last: v_last};
                        n_k   = r_k + LEN_W'(1);
                        if (v_last) begin
                            do_clear = 1'b1;
                            n_len    = '0;
                            n_state  = S_IDLE;
                        end else begin
                            n_i     = r_i + LEN_W'(1);
                            n_state = S_RD;
                        end
                    end
                end else begin
                    n_i     = r_i + LEN_W'(1);
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
            r_c     <= '0;
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ov    <= n_ov;
            r_found <= n_found;
            r_c     <= n_c;
            r_i     <= n_i;
            r_k     <= n_k;
        end
        r_best   <= n_best;
        r_best_n <= n_best_n;
        r_dep    <= n_dep;
        r_out    <= n_out;
    end

    // color tallies and satisfied flags, updated in place per entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_COLORS; i++) begin
                r_tally[i] <= '0;
            end
            r_sat <= '0;
        end else begin
            for (int i = 0; i < MAX_COLORS; i++) begin
                if (do_clear) begin
                    r_tally[i] <= '0;
                end else if (do_load && q_col_x == NC_W'(i)) begin
                    r_tally[i] <= r_tally[i] + LEN_W'(1);
                end
                if (do_set && q_col_x == NC_W'(i)) begin
                    r_sat[i] <= 1'b1;
                end else if (do_unset && q_col_x == NC_W'(i)) begin
                    r_sat[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_rec) begin
            r_cad[r_dep] <= COLOR_W'(r_best);
        end
    end

    // candidate list: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_list_pt[r_len[IDX_W-1:0]]  <= POINT_BITS'(i_q_cmd.point);
            r_list_col[r_len[IDX_W-1:0]] <= i_q_cmd.color;
        end
        r_rd_pt  <= r_list_pt[r_i[IDX_W-1:0]];
        r_rd_col <= r_list_col[r_i[IDX_W-1:0]];
    end

    assign o_out.valid        = r_ov;
    assign o_out.candidate    = r_out.candidate;
    assign o_out.chosen_color = r_out.chosen_color;
    assign o_out.count        = r_out.count;
    assign o_out.status       = r_out.status;
    assign o_out.last         = r_out.last;

    property p_len_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_len <= LEN_W'(LIST_DEPTH);
    endproperty
    a_len_bound: assert property (p_len_bound) else $error("list length overrun");

    property p_walk_count;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_CHK) |-> (r_k < r_best_n);
    endproperty
    a_walk_count: assert property (p_walk_count) else $error("select emitted too many");

    property p_scan_bound;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_SCAN) |-> (r_c <= i_nc);
    endproperty
    a_scan_bound: assert property (p_scan_bound) else $error("scan ran past colors");

    property p_clear_empties;
        @(posedge i_clk) disable iff (!i_rst_n) do_clear |=> (r_len == '0);
    endproperty
    a_clear_empties: assert property (p_clear_empties) else $error("list not cleared");

    property p_walk_found;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_RD || r_state == S_CHK) |-> (r_found && r_best_n != '0);
    endproperty
    a_walk_found: assert property (p_walk_found) else $error("walk without a choice");

endmodule
